FILE: sv/mlbc_pkg.sv
// Shared types and constants for the multi-LED blink controller.
// Used by the controller, the datapath and the top level; depends on nothing.
package mlbc_pkg;

    localparam int NUM_LEDS   = 8;
    localparam int LED_AW     = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int CMP_W      = 5;
    localparam int VAL_W      = 16;
    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 16;
    localparam int PIN_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int COUNT_W    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MASK = 1'b1;

    localparam logic [COUNT_W-1:0] LED_COUNT_RESET   = 4'd8;
    localparam logic [PIN_W-1:0]   ACTIVE_MASK_RESET = 8'hFF;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_ON     = 3'd1,
        OP_OFF    = 3'd2,
        OP_TOGGLE = 3'd3,
        OP_BLINK  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMD,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_item;
        logic do_cmd;
        logic do_walk;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic walk_last;
        logic out_free;
    } dp_status_t;

endpackage

FILE: sv/mlbc_ctrl.sv
// Sequencing state machine of the multi-LED blink controller.
// Depends on mlbc_pkg; drives the datapath through command and status structs.
module mlbc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  mlbc_pkg::dp_status_t   status,
    output mlbc_pkg::ctrl_cmd_t    cmd
);
    import mlbc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_CMD;
                end
            end
            ST_CMD:
            begin
                state_next = status.is_tick ? ST_WALK : ST_DONE;
            end
            ST_WALK:
            begin
                if (status.walk_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready      = 1'b0;
        cmd.load_item = 1'b0;
        cmd.do_cmd    = 1'b0;
        cmd.do_walk   = 1'b0;
        cmd.load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            ST_CMD:
            begin
                cmd.do_cmd = !status.is_tick;
            end
            ST_WALK:
            begin
                cmd.do_walk = 1'b1;
            end
            ST_DONE:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Only one datapath action per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_item, cmd.do_cmd, cmd.do_walk, cmd.load_out}))
        else $error("mlbc_ctrl: more than one datapath action in a cycle");

    // The walk ends after its last LED.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_walk && status.walk_last |=> !cmd.do_walk)
        else $error("mlbc_ctrl: walk continued past the last LED");

    // An accepted item is always followed by its command phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_item |=> (state_reg == ST_CMD))
        else $error("mlbc_ctrl: accepted item did not enter the command phase");

endmodule

FILE: sv/mlbc_datapath.sv
// Datapath of the multi-LED blink controller: item registers, per-LED state,
// configuration registers and the output register. Depends on mlbc_pkg.
module mlbc_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mlbc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mlbc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [mlbc_pkg::IN_USER_W-1:0]        s_tuser,
    input  logic [mlbc_pkg::IN_DATA_W-1:0]        s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [mlbc_pkg::OUT_DATA_W-1:0]       m_tdata,
    input  mlbc_pkg::ctrl_cmd_t                   cmd,
    output mlbc_pkg::dp_status_t                  status
);
    import mlbc_pkg::*;

    logic [COUNT_W-1:0] led_count_reg;
    logic [PIN_W-1:0]   mask_reg;

    op_t                op_reg;
    logic [2:0]         idx_reg;
    logic [VAL_W-1:0]   interval_in_reg;
    logic [VAL_W-1:0]   count_in_reg;
    logic [VAL_W-1:0]   tick_reg;

    logic [NUM_LEDS-1:0] lit_reg;
    logic [NUM_LEDS-1:0] en_reg;
    logic [VAL_W-1:0]    interval_reg [NUM_LEDS];
    logic [VAL_W-1:0]    elapsed_reg  [NUM_LEDS];
    logic [VAL_W-1:0]    toggles_reg  [NUM_LEDS];

    logic [LED_AW-1:0]   walk_reg;

    logic                   m_tvalid_reg;
    logic [OUT_DATA_W-1:0]  m_tdata_reg;

    logic [LED_AW-1:0]   addr;
    logic                cmd_ok;
    logic                walk_ok;
    logic                bad;
    logic                status_bit;
    logic [VAL_W:0]      sum_full;
    logic [VAL_W-1:0]    sum;
    logic [VAL_W-1:0]    toggles_dec;
    logic                blink_stop;
    logic [PIN_W-1:0]    pins;
    logic                any_blink;

    assign addr    = cmd.do_walk ? walk_reg : LED_AW'(idx_reg);
    assign cmd_ok  = (CMP_W'(idx_reg) < CMP_W'(NUM_LEDS)) &&
                     (CMP_W'(idx_reg) < CMP_W'(led_count_reg));
    assign walk_ok = CMP_W'(walk_reg) < CMP_W'(led_count_reg);

    always_comb
    begin
        unique case (op_reg)
            OP_TICK:   bad = 1'b0;
            OP_ON:     bad = !cmd_ok;
            OP_OFF:    bad = !cmd_ok;
            OP_TOGGLE: bad = !cmd_ok;
            OP_BLINK:  bad = !cmd_ok || (interval_in_reg == '0);
            default:   bad = 1'b1;
        endcase
    end

    assign status_bit  = bad;
    assign sum_full    = {1'b0, elapsed_reg[addr]} + {1'b0, tick_reg};
    assign sum         = sum_full[VAL_W-1:0];
    assign toggles_dec = toggles_reg[addr] - VAL_W'(1);
    assign blink_stop  = (toggles_reg[addr] != '0) && (toggles_dec == '0);
    assign any_blink   = |en_reg;

    for (genvar j = 0; j < PIN_W; j++)
    begin : g_pin
        if (j < NUM_LEDS)
        begin : g_used
            assign pins[j] = lit_reg[j] ~^ mask_reg[j];
        end
        else
        begin : g_none
            assign pins[j] = 1'b0;
        end
    end

    assign status.is_tick   = (op_reg == OP_TICK);
    assign status.walk_last = (walk_reg == LED_AW'(NUM_LEDS - 1));
    assign status.out_free  = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg <= LED_COUNT_RESET;
            mask_reg      <= ACTIVE_MASK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LED_COUNT:   led_count_reg <= cfg_data[COUNT_W-1:0];
                REG_ACTIVE_MASK: mask_reg      <= cfg_data[PIN_W-1:0];
                default:         mask_reg      <= mask_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg          <= op_t'(s_tuser);
            idx_reg         <= s_tdata[2:0];
            interval_in_reg <= s_tdata[18:3];
            count_in_reg    <= s_tdata[34:19];
            tick_reg        <= s_tdata[50:35];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg <= '0;
        end
        else if (cmd.load_item)
        begin
            walk_reg <= '0;
        end
        else if (cmd.do_walk && !status.walk_last)
        begin
            walk_reg <= walk_reg + LED_AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lit_reg <= '0;
            en_reg  <= '0;
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                interval_reg[i] <= '0;
                elapsed_reg[i]  <= '0;
                toggles_reg[i]  <= '0;
            end
        end
        else if (cmd.do_cmd && !bad)
        begin
            unique case (op_reg)
                OP_ON, OP_OFF:
                begin
                    lit_reg[addr]      <= (op_reg == OP_ON);
                    en_reg[addr]       <= 1'b0;
                    interval_reg[addr] <= '0;
                    elapsed_reg[addr]  <= '0;
                    toggles_reg[addr]  <= '0;
                end
                OP_TOGGLE:
                begin
                    lit_reg[addr] <= !lit_reg[addr];
                end
                OP_BLINK:
                begin
                    en_reg[addr]       <= 1'b1;
                    interval_reg[addr] <= interval_in_reg;
                    elapsed_reg[addr]  <= '0;
                    toggles_reg[addr]  <= count_in_reg;
                end
                default:
                begin
                    en_reg <= en_reg;
                end
            endcase
        end
        else if (cmd.do_walk && en_reg[addr])
        begin
            if (sum < interval_reg[addr])
            begin
                elapsed_reg[addr] <= sum;
            end
            else
            begin
                elapsed_reg[addr] <= '0;
                if (walk_ok)
                begin
                    lit_reg[addr] <= blink_stop ? 1'b0 : !lit_reg[addr];
                end
                if (toggles_reg[addr] != '0)
                begin
                    toggles_reg[addr] <= toggles_dec;
                end
                if (blink_stop)
                begin
                    en_reg[addr]       <= 1'b0;
                    interval_reg[addr] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            m_tdata_reg <= {6'b0, any_blink, status_bit, pins};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A result is never loaded over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("mlbc_datapath: result overwritten before it was taken");

    // Every walk starts from the first LED.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_item |=> (walk_reg == '0))
        else $error("mlbc_datapath: walk counter not cleared for a new item");

endmodule

FILE: sv/multi_led_blink_controller.sv
// Top level of the multi-LED blink controller: joins the controller and the
// datapath. Depends on mlbc_pkg, mlbc_ctrl and mlbc_datapath.
//
//   channel   direction  fields (lowest bit first)
//   cfg       in         cfg_index: 0 led_count, 1 active_high_mask; cfg_data
//   s         in         tuser: opcode; tdata: led_index, blink interval,
//                        toggle limit, tick_ms
//   m         out        tdata: pin_levels, status, any_blinking
//
// On, off, toggle, start blinking and rejected items pass from acceptance
// through the command and done states to a valid result; a tick walks the
// per-LED timer state, every LED entry in turn, through one shared adder.
// A new item is accepted while a previous result still waits on m; the result
// stage holds until taken. Reset sets every LED off and not blinking.
module multi_led_blink_controller (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mlbc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mlbc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // opcode[2:0]
    input  logic [mlbc_pkg::IN_USER_W-1:0]        s_tuser,
    // led_index[2:0], interval[18:3], toggle_limit[34:19], tick_ms[50:35]
    input  logic [mlbc_pkg::IN_DATA_W-1:0]        s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // pin_levels[7:0], status[8], any_blinking[9]
    output logic [mlbc_pkg::OUT_DATA_W-1:0]       m_tdata
);
    import mlbc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    mlbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mlbc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

FILE: tb/multi_led_blink_controller_tb.sv
// Self-checking testbench for the multi-LED blink controller: directed and random command
// items are checked against a predictor of the LED and blink timer state kept in this file.
// Depends on mlbc_pkg and multi_led_blink_controller.
module multi_led_blink_controller_tb;

    import mlbc_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = NUM_LEDS + 3 + 8;
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [2:0]  led;
        logic [15:0] interval;
        logic [15:0] repeats;
        logic [15:0] step_ms;
    } led_cmd_t;

    typedef struct packed {
        logic [7:0] pins;
        logic       status;
        logic       blinking;
    } led_view_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    led_cmd_t  cmd_queue[$];
    led_view_t view_queue[$];
    led_cmd_t  cmd_on_bus;
    led_view_t view_want;

    int queued_total = 0;
    int accepted_total = 0;
    int checked_total = 0;
    int error_count = 0;
    int cycle_count = 0;
    int send_gap = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    logic [3:0]  leds_in_use;
    logic [7:0]  lit_high_mask;
    logic        lit_now[NUM_LEDS];
    logic        blink_on[NUM_LEDS];
    logic [15:0] period_ms[NUM_LEDS];
    logic [15:0] elapsed_acc[NUM_LEDS];
    logic [15:0] toggles_left[NUM_LEDS];

    multi_led_blink_controller uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser(s_tuser),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #5 clk = ~clk;

    function automatic bit led_addressable(int i);
        return i < NUM_LEDS && i < int'(leds_in_use);
    endfunction

    function automatic void stop_blink(int i);
        blink_on[i] = 1'b0;
        period_ms[i] = '0;
        elapsed_acc[i] = '0;
        toggles_left[i] = '0;
    endfunction

    task automatic predict_view(input led_cmd_t c);
        led_view_t v;
        int i;
        v = '0;
        case (c.opcode)
            OP_TICK:
            begin
                for (i = 0; i < NUM_LEDS; i++)
                begin
                    if (blink_on[i])
                    begin
                        elapsed_acc[i] = elapsed_acc[i] + c.step_ms;
                        if (elapsed_acc[i] >= period_ms[i])
                        begin
                            elapsed_acc[i] = '0;
                            if (led_addressable(i))
                                lit_now[i] = ~lit_now[i];
                            if (toggles_left[i] != '0)
                            begin
                                toggles_left[i] = toggles_left[i] - 16'd1;
                                if (toggles_left[i] == '0)
                                begin
                                    stop_blink(i);
                                    if (led_addressable(i))
                                        lit_now[i] = 1'b0;
                                end
                            end
                        end
                    end
                end
            end
            OP_ON, OP_OFF, OP_TOGGLE, OP_BLINK:
            begin
                if (!led_addressable(c.led) || (c.opcode == OP_BLINK && c.interval == 0))
                    v.status = 1'b1;
                else if (c.opcode == OP_ON)
                begin
                    stop_blink(c.led);
                    lit_now[c.led] = 1'b1;
                end
                else if (c.opcode == OP_OFF)
                begin
                    stop_blink(c.led);
                    lit_now[c.led] = 1'b0;
                end
                else if (c.opcode == OP_TOGGLE)
                    lit_now[c.led] = ~lit_now[c.led];
                else
                begin
                    blink_on[c.led] = 1'b1;
                    period_ms[c.led] = c.interval;
                    elapsed_acc[c.led] = '0;
                    toggles_left[c.led] = c.repeats;
                end
            end
            default:
                v.status = 1'b1;
        endcase
        for (i = 0; i < NUM_LEDS; i++)
        begin
            if (i < 8)
                v.pins[i] = lit_now[i] ^ ~lit_high_mask[i];
            if (blink_on[i])
                v.blinking = 1'b1;
        end
        view_queue.push_back(v);
    endtask

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on item %0d: %s got 0x%0h expected 0x%0h",
                 checked_total, field, got, want);
        error_count++;
    endtask

    task automatic queue_cmd(input logic [2:0] op, input logic [2:0] led,
                             input logic [15:0] interval, input logic [15:0] repeats,
                             input logic [15:0] step_ms);
        led_cmd_t c;
        c.opcode = op;
        c.led = led;
        c.interval = interval;
        c.repeats = repeats;
        c.step_ms = step_ms;
        cmd_queue.push_back(c);
        queued_total++;
    endtask

    task automatic queue_random_cmd();
        logic [2:0]  op;
        logic [15:0] interval;
        logic [15:0] repeats;
        logic [15:0] step_ms;
        int r;
        r = $urandom_range(0, 99);
        interval = 16'($urandom);
        repeats = 16'($urandom);
        step_ms = 16'($urandom);
        if (r < 45)
        begin
            op = OP_TICK;
            r = $urandom_range(0, 9);
            if (r < 7)
                step_ms = 16'($urandom_range(0, 8));
            else if (r < 9)
                step_ms = 16'($urandom_range(0, 300));
        end
        else if (r < 62)
        begin
            op = OP_BLINK;
            r = $urandom_range(0, 19);
            if (r < 15)
                interval = 16'($urandom_range(1, 12));
            else if (r < 17)
                interval = '0;
            r = $urandom_range(0, 9);
            if (r < 4)
                repeats = '0;
            else if (r < 8)
                repeats = 16'($urandom_range(1, 6));
        end
        else if (r < 72)
            op = OP_ON;
        else if (r < 80)
            op = OP_OFF;
        else if (r < 90)
            op = OP_TOGGLE;
        else if (r < 95)
            op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        else
            op = 3'($urandom_range(0, 7));
        queue_cmd(op, 3'($urandom_range(0, 7)), interval, repeats, step_ms);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [7:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        if (index == REG_LED_COUNT)
            leds_in_use = value[3:0];
        else
            lit_high_mask = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        wait (accepted_total == queued_total && checked_total == queued_total);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            predict_view(cmd_on_bus);
            accepted_total++;
        end
        if (!s_tvalid || s_tready)
        begin
            if (send_gap > 0 || !rst_n || cmd_queue.size() == 0)
            begin
                if (send_gap > 0)
                    send_gap--;
                s_tvalid <= 1'b0;
            end
            else
            begin
                cmd_on_bus = cmd_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= cmd_on_bus.opcode;
                s_tdata <= {5'b0, cmd_on_bus.step_ms, cmd_on_bus.repeats,
                            cmd_on_bus.interval, cmd_on_bus.led};
                send_gap = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (view_queue.size() == 0)
                report_mismatch("unexpected result", int'(m_tdata), 0);
            else
            begin
                view_want = view_queue.pop_front();
                if (m_tdata[7:0] !== view_want.pins)
                    report_mismatch("pin_levels", int'(m_tdata[7:0]), int'(view_want.pins));
                if (m_tdata[8] !== view_want.status)
                    report_mismatch("status", int'(m_tdata[8]), int'(view_want.status));
                if (m_tdata[9] !== view_want.blinking)
                    report_mismatch("any_blinking", int'(m_tdata[9]),
                                    int'(view_want.blinking));
                checked_total++;
            end
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < 25)
                stall_left = idle_len();
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("multi_led_blink_controller verification failed");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int n;
        int items;
        logic [3:0] count_sel;
        logic [7:0] mask_sel;
        leds_in_use = LED_COUNT_RESET;
        lit_high_mask = ACTIVE_MASK_RESET;
        for (n = 0; n < NUM_LEDS; n++)
        begin
            lit_now[n] = 1'b0;
            stop_blink(n);
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        queue_cmd(OP_ON, 3'd0, 16'h0000, 16'h0000, 16'hFFFF);
        queue_cmd(OP_ON, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_cmd(OP_OFF, 3'd7, 16'h0000, 16'h0000, 16'h0000);
        queue_cmd(OP_TOGGLE, 3'd3, 16'h0000, 16'h0000, 16'h0000);
        queue_cmd(OP_TOGGLE, 3'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_cmd(OP_BLINK, 3'd1, 16'h0000, 16'h0005, 16'h0000);
        queue_cmd(OP_BLINK, 3'd2, 16'h0001, 16'h0000, 16'h0000);
        queue_cmd(OP_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000);
        queue_cmd(OP_TICK, 3'd7, 16'hFFFF, 16'hFFFF, 16'h0001);
        queue_cmd(OP_BLINK, 3'd5, 16'hFFFF, 16'hFFFF, 16'h0000);
        queue_cmd(OP_TICK, 3'd0, 16'h0000, 16'h0000, 16'hFFFE);
        queue_cmd(OP_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0002);
        queue_cmd(OP_TICK, 3'd0, 16'h0000, 16'h0000, 16'hFFFF);
        queue_cmd(OP_BLINK, 3'd6, 16'h0003, 16'h0001, 16'h0000);
        queue_cmd(OP_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0003);
        queue_cmd(OP_BLINK, 3'd4, 16'h0002, 16'h0002, 16'h0000);
        queue_cmd(OP_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0002);
        queue_cmd(OP_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0002);
        queue_cmd(OP_UNUSED_FIRST, 3'd0, 16'h0001, 16'h0001, 16'h0001);
        queue_cmd(OP_UNUSED_LAST, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_cmd(OP_BLINK, 3'd7, 16'h0004, 16'h0000, 16'h0000);
        wait_idle();

        write_reg(REG_LED_COUNT, 8'h00);
        write_reg(REG_ACTIVE_MASK, 8'h00);
        queue_cmd(OP_ON, 3'd0, 16'h0000, 16'h0000, 16'h0000);
        queue_cmd(OP_BLINK, 3'd0, 16'h0001, 16'h0000, 16'h0000);
        queue_cmd(OP_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0004);
        wait_idle();

        write_reg(REG_LED_COUNT, 8'hF3);
        write_reg(REG_ACTIVE_MASK, 8'hA5);
        queue_cmd(OP_ON, 3'd2, 16'h0000, 16'h0000, 16'h0000);
        queue_cmd(OP_ON, 3'd3, 16'h0000, 16'h0000, 16'h0000);
        queue_cmd(OP_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0004);
        wait_idle();

        for (phase = 0; phase < 6; phase++)
        begin
            items = 105;
            case (phase)
                0:
                begin
                    count_sel = 4'd8;
                    mask_sel = 8'($urandom);
                end
                1:
                begin
                    count_sel = 4'd1;
                    mask_sel = 8'h00;
                end
                2:
                begin
                    count_sel = 4'd15;
                    mask_sel = 8'hFF;
                end
                3:
                begin
                    count_sel = 4'd0;
                    mask_sel = 8'($urandom);
                    items = 40;
                end
                4:
                begin
                    count_sel = 4'($urandom_range(1, 8));
                    mask_sel = 8'($urandom);
                end
                default:
                begin
                    count_sel = 4'd8;
                    mask_sel = 8'($urandom);
                end
            endcase
            calm = (phase == 2);
            write_reg(REG_LED_COUNT, {4'($urandom), count_sel});
            write_reg(REG_ACTIVE_MASK, mask_sel);
            for (n = 0; n < items; n++)
                queue_random_cmd();
            wait_idle();
        end

        if (view_queue.size() != 0)
            report_mismatch("results left over", view_queue.size(), 0);
        if (error_count == 0)
            $display("multi_led_blink_controller verification clean");
        else
            $display("multi_led_blink_controller verification failed");
        $finish;
    end

endmodule
